FILE: sv/canonical_huffman_encoder_unit_assert.svh
// Assertion macros for the canonical Huffman encoder unit.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef CANONICAL_HUFFMAN_ENCODER_UNIT_ASSERT_SVH
`define CANONICAL_HUFFMAN_ENCODER_UNIT_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define CHU_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CHU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CHU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/chu_pkg.sv
// Package for the canonical Huffman encoder unit: field widths, defaults,
// function codes and controller states. No dependencies.
`default_nettype none
package chu_pkg;

    localparam int MAX_CODE_LEN_DEF = 16;
    localparam int SYMBOL_COUNT_DEF = 256;

    localparam int FUNC_W = 2;
    localparam int SYM_W  = 8;
    localparam int LEN_W  = 5;
    localparam int BYTE_W = 8;
    localparam int HELD_W = 4;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ENCODE = 2'd1,
        FUNC_FINISH = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_PACK,
        ST_FIN_BYTE,
        ST_FIN_CNT
    } state_t;

endpackage
`default_nettype wire

FILE: sv/chu_cmd_if.sv
// Input channel of the encoder unit: valid/ready plus command word.
// Depends on chu_pkg.
`default_nettype none
interface chu_cmd_if;
    import chu_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_length;

    modport source (output valid, output func, output symbol, output code_length,
                    input ready);
    modport sink   (input valid, input func, input symbol, input code_length,
                    output ready);
endinterface
`default_nettype wire

FILE: sv/chu_res_if.sv
// Output channel of the encoder unit: valid/ready plus result word.
// Depends on chu_pkg.
`default_nettype none
interface chu_res_if;
    import chu_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

FILE: sv/chu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module chu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: sv/canonical_huffman_encoder_unit.sv
// Canonical Huffman encoder unit. Load: no result. Encode: a code table read, then the code
// is packed one chunk per step, a full byte buffer being emitted first; out-of-range symbol:
// no result. Finish: emits the buffer byte, then the held bit count as the last byte.
// Output stalls hold packing and finish. One command word at a time.
// Reset (async, rst_n low) clears per-symbol valid bits, so every symbol reads as length 0.
// Depends on chu_pkg, chu_cmd_if, chu_res_if, chu_ram and the assertion header.
`default_nettype none
module canonical_huffman_encoder_unit #(
    parameter int MAX_CODE_LEN = chu_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = chu_pkg::SYMBOL_COUNT_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    chu_cmd_if.sink    cmd,
    chu_res_if.source  res
);
    import chu_pkg::*;

    `include "canonical_huffman_encoder_unit_assert.svh"

    localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
    localparam int NC_W    = MAX_CODE_LEN + 1;
    localparam int ENTRY_W = MAX_CODE_LEN + LEN_W;
    localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);

    state_t state_reg, state_next;

    logic [SYMBOL_COUNT-1:0] valid_bits_reg, valid_bits_next;
    logic [NC_W-1:0]         next_code_reg, next_code_next;
    logic [LEN_W-1:0]        prev_len_reg, prev_len_next;
    logic [BYTE_W-1:0]       buf_reg, buf_next;
    logic [HELD_W-1:0]       held_reg, held_next;
    logic [LEN_W-1:0]        rem_reg, rem_next;
    logic                    hit_reg, hit_next;
    logic                    out_valid_reg, out_valid_next;
    logic [MAX_CODE_LEN-1:0] code_reg, code_next;
    logic [BYTE_W-1:0]       out_byte_reg, out_byte_next;
    logic                    out_last_reg, out_last_next;

    logic                    accept;
    logic                    slot_free;
    logic                    sym_ok;
    logic [ADDR_W-1:0]       addr;
    logic [LEN_W-1:0]        len_sat;
    logic [LEN_W-1:0]        growth;
    logic [NC_W-1:0]         nc_shift;
    logic [MAX_CODE_LEN-1:0] code_mask;
    logic [MAX_CODE_LEN-1:0] load_code;
    logic                    ram_we;
    logic [ENTRY_W-1:0]      ram_rdata;
    logic [MAX_CODE_LEN-1:0] rd_code;
    logic [LEN_W-1:0]        rd_len;

    logic [HELD_W-1:0]       base_held;
    logic [BYTE_W-1:0]       base_buf;
    logic [HELD_W-1:0]       room;
    logic [HELD_W-1:0]       take_k;
    logic [MAX_CODE_LEN-1:0] shifted;
    logic [BYTE_W-1:0]       chunk;
    logic [BYTE_W-1:0]       placed;
    logic                    need_emit;
    logic                    pack_go;

    assign cmd.ready    = (state_reg == ST_IDLE);
    assign accept       = cmd.valid && cmd.ready;
    assign slot_free    = !out_valid_reg || res.ready;
    assign res.valid    = out_valid_reg;
    assign res.out_byte = out_byte_reg;
    assign res.last     = out_last_reg;

    assign sym_ok = ({1'b0, cmd.symbol} < SYM_LIMIT);
    assign addr   = cmd.symbol[ADDR_W-1:0];

    // canonical code assignment
    assign len_sat   = (int'(cmd.code_length) > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN)
                                                               : cmd.code_length;
    assign growth    = (len_sat > prev_len_reg) ? len_sat - prev_len_reg : '0;
    assign nc_shift  = next_code_reg << growth;
    assign code_mask = ~({MAX_CODE_LEN{1'b1}} << len_sat);
    assign load_code = nc_shift[MAX_CODE_LEN-1:0] & code_mask;
    assign ram_we    = accept && (cmd.func == FUNC_LOAD) && (cmd.code_length != '0)
                       && sym_ok;

    chu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_code_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata ({load_code, len_sat}),
        .re    (accept),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    assign rd_code = ram_rdata[ENTRY_W-1:LEN_W];
    assign rd_len  = hit_reg ? ram_rdata[LEN_W-1:0] : '0;

    // bit packer: one chunk of up to a byte per step
    assign base_held = (held_reg == 4'd8) ? '0 : held_reg;
    assign base_buf  = (held_reg == 4'd8) ? '0 : buf_reg;
    assign room      = 4'd8 - base_held;
    assign take_k    = (LEN_W'(room) < rem_reg) ? room : rem_reg[HELD_W-1:0];
    assign shifted   = code_reg >> (rem_reg - LEN_W'(take_k));
    assign chunk     = shifted[BYTE_W-1:0] & (8'hFF >> (4'd8 - take_k));
    assign placed    = chunk << (4'd8 - base_held - take_k);
    assign need_emit = (held_reg == 4'd8);
    assign pack_go   = (rem_reg != '0) && (!need_emit || slot_free);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.func == FUNC_ENCODE && sym_ok)
                    begin
                        state_next = ST_LOOKUP;
                    end
                    else if (cmd.func == FUNC_FINISH)
                    begin
                        state_next = ST_FIN_BYTE;
                    end
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_PACK;
            end
            ST_PACK:
            begin
                if (rem_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN_BYTE:
            begin
                if (slot_free)
                begin
                    state_next = ST_FIN_CNT;
                end
            end
            ST_FIN_CNT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_bits_next = valid_bits_reg;
        next_code_next  = next_code_reg;
        prev_len_next   = prev_len_reg;
        buf_next        = buf_reg;
        held_next       = held_reg;
        rem_next        = rem_reg;
        hit_next        = hit_reg;
        code_next       = code_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !res.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                hit_next = valid_bits_reg[addr];
                if (ram_we)
                begin
                    valid_bits_next[addr] = 1'b1;
                    next_code_next        = nc_shift + NC_W'(1);
                    prev_len_next         = len_sat;
                end
            end
            ST_LOOKUP:
            begin
                code_next = rd_code;
                rem_next  = rd_len;
            end
            ST_PACK:
            begin
                if (pack_go)
                begin
                    if (need_emit)
                    begin
                        out_byte_next  = buf_reg;
                        out_last_next  = (rem_reg <= 5'd8);
                        out_valid_next = 1'b1;
                    end
                    buf_next  = base_buf | placed;
                    held_next = base_held + take_k;
                    rem_next  = rem_reg - LEN_W'(take_k);
                end
            end
            ST_FIN_BYTE:
            begin
                if (slot_free)
                begin
                    out_byte_next  = buf_reg;
                    out_last_next  = 1'b0;
                    out_valid_next = 1'b1;
                end
            end
            ST_FIN_CNT:
            begin
                if (slot_free)
                begin
                    out_byte_next  = BYTE_W'(held_reg);
                    out_last_next  = 1'b1;
                    out_valid_next = 1'b1;
                    next_code_next = '0;
                    prev_len_next  = '0;
                    buf_next       = '0;
                    held_next      = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_bits_reg <= '0;
            next_code_reg  <= '0;
            prev_len_reg   <= '0;
            buf_reg        <= '0;
            held_reg       <= '0;
            rem_reg        <= '0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_bits_reg <= valid_bits_next;
            next_code_reg  <= next_code_next;
            prev_len_reg   <= prev_len_next;
            buf_reg        <= buf_next;
            held_reg       <= held_next;
            rem_reg        <= rem_next;
            hit_reg        <= hit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    `CHU_ASSERT_ALWAYS(a_held_range, held_reg <= 4'd8, "bit count above one byte")
    `CHU_ASSERT_IMP(a_emit_source, $rose(out_valid_reg),
        $past(state_reg) == ST_PACK || $past(state_reg) == ST_FIN_BYTE ||
        $past(state_reg) == ST_FIN_CNT, "result word raised outside an emitting state")
    `CHU_ASSERT_NXT(a_finish_clears, state_reg == ST_FIN_CNT && slot_free,
        held_reg == '0 && buf_reg == '0 && next_code_reg == '0,
        "finish left bit or code state behind")
    `CHU_ASSERT_IMP(a_no_accept_busy, state_reg != ST_IDLE, !accept,
        "command word taken while busy")

endmodule
`default_nettype wire
